// File: rtl/core/wh2d_pkg.sv
// Shared types, constants and helpers of the weighted 2D histogram binner.
// No dependencies; every other file in rtl/core but wh2d_ram imports this package.
package wh2d_pkg;

    localparam int MAX_BINS_X = 32;
    localparam int MAX_BINS_Y = 32;
    localparam int MAX_BINS   = (MAX_BINS_X > MAX_BINS_Y) ? MAX_BINS_X : MAX_BINS_Y;
    localparam int DEPTH      = MAX_BINS_X * MAX_BINS_Y;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int BIN_W      = $clog2(MAX_BINS + 1);

    localparam int VAL_W     = 32;
    localparam int W_W       = 16;
    localparam int PROD_W    = 2 * W_W;
    localparam int TOT_W     = 48;
    localparam int CNT_W     = 6;
    localparam int IDX_W     = 5;
    localparam int EDGE_W    = VAL_W + 3;
    localparam int DIV_W     = VAL_W + 1;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_CW   = $clog2(DIV_STEPS);
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] MODE_FILL  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [2:0] REG_X_LO  = 3'd0;
    localparam logic [2:0] REG_X_HI  = 3'd1;
    localparam logic [2:0] REG_Y_LO  = 3'd2;
    localparam logic [2:0] REG_Y_HI  = 3'd3;
    localparam logic [2:0] REG_X_CNT = 3'd4;
    localparam logic [2:0] REG_Y_CNT = 3'd5;
    localparam logic [2:0] REG_X_LOG = 3'd6;
    localparam logic [2:0] REG_Y_LOG = 3'd7;

    typedef struct packed {
        logic signed [VAL_W-1:0] x_lo;
        logic signed [VAL_W-1:0] x_hi;
        logic signed [VAL_W-1:0] y_lo;
        logic signed [VAL_W-1:0] y_hi;
        logic [CNT_W-1:0]        x_cnt;
        logic [CNT_W-1:0]        y_cnt;
        logic                    x_log;
        logic                    y_log;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic axis;
        logic ax_init;
        logic div_step;
        logic div_fix;
        logic walk;
        logic rd_fill;
        logic wb_fill;
        logic rd_read;
        logic res_read;
        logic res_zero;
        logic clr_init;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic log_axis;
        logic found;
        logic last;
        logic clr_last;
    } sts_t;

    // Bin count in use, limited to the store's size on that axis.
    function automatic logic [BIN_W-1:0] clamp_bins(input logic [CNT_W-1:0] cnt,
                                                   input int maxv);
        logic [BIN_W-1:0] res;
        if (int'(cnt) > maxv)
            res = BIN_W'(maxv);
        else
            res = BIN_W'(cnt);
        return res;
    endfunction

endpackage

// File: rtl/core/weighted_2d_histogram_binner.sv
// Top level of the weighted 2D histogram binner: registers, controller, datapath.
// Depends on wh2d_pkg, wh2d_regs, wh2d_ctrl, wh2d_dp (and wh2d_ram inside it).
//
//  Channel   Signals                                          Handshake
//  --------  -----------------------------------------------  ----------------------
//  request   mode sample_x sample_y weight_a weight_b         start & !busy
//            read_bin_x read_bin_y
//  result    hit found_bin_x found_bin_y bin_total saturated  done, one cycle
//  config    psel penable pwrite paddr pwdata prdata pready   APB, pready tied high
//
// Fill: per linear axis a setup step, divider steps, a fix step and then edge
// steps; a log axis skips the divider. Then a store read-modify-write. The serial
// divider and the edge walk set the worst case from accept to result. Read takes a
// store read and an output step; an unused mode returns an empty result. A clear sweeps the
// 1024-entry store, one entry a cycle; reset and a bin count write made while idle or
// clearing start the same pass, with busy high throughout. Results cannot be stalled.
module weighted_2d_histogram_binner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wh2d_pkg::PADDR_W-1:0]       paddr,
    input  logic [wh2d_pkg::PDATA_W-1:0]       pwdata,
    output logic [wh2d_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         mode,
    input  logic signed [wh2d_pkg::VAL_W-1:0]  sample_x,
    input  logic signed [wh2d_pkg::VAL_W-1:0]  sample_y,
    input  logic signed [wh2d_pkg::W_W-1:0]    weight_a,
    input  logic signed [wh2d_pkg::W_W-1:0]    weight_b,
    input  logic [wh2d_pkg::IDX_W-1:0]         read_bin_x,
    input  logic [wh2d_pkg::IDX_W-1:0]         read_bin_y,
    output logic                               done,
    output logic                               hit,
    output logic [wh2d_pkg::IDX_W-1:0]         found_bin_x,
    output logic [wh2d_pkg::IDX_W-1:0]         found_bin_y,
    output logic signed [wh2d_pkg::TOT_W-1:0]  bin_total,
    output logic                               saturated
);
    import wh2d_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic cfg_clear;

    wh2d_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    wh2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .cfg_clear (cfg_clear),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    wh2d_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .sample_x    (sample_x),
        .sample_y    (sample_y),
        .weight_a    (weight_a),
        .weight_b    (weight_b),
        .read_bin_x  (read_bin_x),
        .read_bin_y  (read_bin_y),
        .hit         (hit),
        .found_bin_x (found_bin_x),
        .found_bin_y (found_bin_y),
        .bin_total   (bin_total),
        .saturated   (saturated)
    );

endmodule

// File: rtl/core/wh2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module wh2d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/wh2d_regs.sv
// APB-style configuration registers of the histogram binner.
// Depends on wh2d_pkg for cfg_t and register indexes.
module wh2d_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wh2d_pkg::PADDR_W-1:0]  paddr,
    input  logic [wh2d_pkg::PDATA_W-1:0]  pwdata,
    output logic [wh2d_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output wh2d_pkg::cfg_t                cfg,
    output logic                          cfg_clear
);
    import wh2d_pkg::*;

    cfg_t       cfg_reg;
    logic       wr;
    logic [2:0] idx;

    assign wr        = psel && penable && pwrite;
    assign idx       = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;
    // A new bin count asks for a clear of the whole store; the controller acts on it only while idle or clearing.
    assign cfg_clear = wr && (idx == REG_X_CNT || idx == REG_Y_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_lo  <= '0;
            cfg_reg.x_hi  <= 32'sd65536;
            cfg_reg.y_lo  <= '0;
            cfg_reg.y_hi  <= 32'sd65536;
            cfg_reg.x_cnt <= CNT_W'(32);
            cfg_reg.y_cnt <= CNT_W'(32);
            cfg_reg.x_log <= 1'b0;
            cfg_reg.y_log <= 1'b0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_X_LO:  cfg_reg.x_lo  <= signed'(pwdata[VAL_W-1:0]);
                REG_X_HI:  cfg_reg.x_hi  <= signed'(pwdata[VAL_W-1:0]);
                REG_Y_LO:  cfg_reg.y_lo  <= signed'(pwdata[VAL_W-1:0]);
                REG_Y_HI:  cfg_reg.y_hi  <= signed'(pwdata[VAL_W-1:0]);
                REG_X_CNT: cfg_reg.x_cnt <= pwdata[CNT_W-1:0];
                REG_Y_CNT: cfg_reg.y_cnt <= pwdata[CNT_W-1:0];
                REG_X_LOG: cfg_reg.x_log <= pwdata[0];
                REG_Y_LOG: cfg_reg.y_log <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_X_LO:  prdata = PDATA_W'(unsigned'(cfg_reg.x_lo));
            REG_X_HI:  prdata = PDATA_W'(unsigned'(cfg_reg.x_hi));
            REG_Y_LO:  prdata = PDATA_W'(unsigned'(cfg_reg.y_lo));
            REG_Y_HI:  prdata = PDATA_W'(unsigned'(cfg_reg.y_hi));
            REG_X_CNT: prdata = PDATA_W'(cfg_reg.x_cnt);
            REG_Y_CNT: prdata = PDATA_W'(cfg_reg.y_cnt);
            REG_X_LOG: prdata = PDATA_W'(cfg_reg.x_log);
            REG_Y_LOG: prdata = PDATA_W'(cfg_reg.y_log);
            default:   prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/wh2d_dp.sv
// Datapath: step divider, edge walker, weight multiplier, bin store and
// result registers. Depends on wh2d_pkg and wh2d_ram.
module wh2d_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wh2d_pkg::cfg_t                     cfg,
    input  wh2d_pkg::cmd_t                     cmd,
    output wh2d_pkg::sts_t                     sts,
    input  logic signed [wh2d_pkg::VAL_W-1:0]  sample_x,
    input  logic signed [wh2d_pkg::VAL_W-1:0]  sample_y,
    input  logic signed [wh2d_pkg::W_W-1:0]    weight_a,
    input  logic signed [wh2d_pkg::W_W-1:0]    weight_b,
    input  logic [wh2d_pkg::IDX_W-1:0]         read_bin_x,
    input  logic [wh2d_pkg::IDX_W-1:0]         read_bin_y,
    output logic                               hit,
    output logic [wh2d_pkg::IDX_W-1:0]         found_bin_x,
    output logic [wh2d_pkg::IDX_W-1:0]         found_bin_y,
    output logic signed [wh2d_pkg::TOT_W-1:0]  bin_total,
    output logic                               saturated
);
    import wh2d_pkg::*;

    localparam logic signed [VAL_W-1:0] V_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] V_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [TOT_W-1:0] T_MAX = {1'b0, {(TOT_W-1){1'b1}}};
    localparam logic signed [TOT_W-1:0] T_MIN = {1'b1, {(TOT_W-1){1'b0}}};
    localparam int M_W = EDGE_W + 4;

    logic signed [VAL_W-1:0]  x_reg, y_reg;
    logic signed [W_W-1:0]    wa_reg, wb_reg;
    logic [IDX_W-1:0]         rx_reg, ry_reg;
    logic signed [PROD_W-1:0] w_reg;
    logic signed [EDGE_W-1:0] cur_reg, step_reg;
    logic [BIN_W-1:0]         n_reg, i_reg, bx_reg, by_reg;
    logic [DIV_W-1:0]         dq_reg;
    logic [BIN_W-1:0]         rem_reg;
    logic                     dneg_reg;
    logic [ADDR_W-1:0]        clr_reg;
    logic                     hit_reg, sat_reg;
    logic [IDX_W-1:0]         fbx_reg, fby_reg;
    logic signed [TOT_W-1:0]  tot_reg;

    logic signed [VAL_W-1:0]  lo_sel, hi_sel, v_sel;
    logic [CNT_W-1:0]         cnt_sel;
    logic                     log_sel;
    logic [BIN_W-1:0]         n_sel, nx, ny;
    logic signed [EDGE_W-1:0] diff, dmag, qext, lin_next, nxt, vv;
    logic [BIN_W:0]           rem_sh;
    logic                     ge;
    logic signed [M_W-1:0]    cw, c10;
    logic signed [VAL_W-1:0]  log_next;
    logic                     last, found, read_ok;
    logic signed [TOT_W:0]    sum;
    logic signed [TOT_W-1:0]  sum_sat;
    logic                     ovf;
    logic [ADDR_W-1:0]        fill_addr, read_addr;
    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    logic [TOT_W-1:0]         mem_wdata, mem_rdata;

    always_comb
    begin
        lo_sel  = cmd.axis ? cfg.y_lo  : cfg.x_lo;
        hi_sel  = cmd.axis ? cfg.y_hi  : cfg.x_hi;
        cnt_sel = cmd.axis ? cfg.y_cnt : cfg.x_cnt;
        log_sel = cmd.axis ? cfg.y_log : cfg.x_log;
        v_sel   = cmd.axis ? y_reg     : x_reg;
        nx      = clamp_bins(cfg.x_cnt, MAX_BINS_X);
        ny      = clamp_bins(cfg.y_cnt, MAX_BINS_Y);
        n_sel   = cmd.axis ? ny : nx;

        diff = EDGE_W'(hi_sel) - EDGE_W'(lo_sel);
        dmag = (diff < 0) ? -diff : diff;

        // One restoring division step: shift in a dividend bit, subtract n where it fits.
        rem_sh = {rem_reg, dq_reg[DIV_W-1]};
        ge     = rem_sh >= {1'b0, n_reg};
        qext   = signed'(EDGE_W'(dq_reg));

        cw  = M_W'(cur_reg);
        c10 = (cw <<< 3) + (cw <<< 1);
        if (c10 > M_W'(V_MAX))
            log_next = V_MAX;
        else if (c10 < M_W'(V_MIN))
            log_next = V_MIN;
        else
            log_next = VAL_W'(c10);

        last     = BIN_W'(i_reg + BIN_W'(1)) == n_reg;
        lin_next = last ? EDGE_W'(hi_sel) : cur_reg + step_reg;
        nxt      = log_sel ? EDGE_W'(log_next) : lin_next;
        vv       = EDGE_W'(v_sel);
        found    = (vv >= cur_reg) && (vv < nxt);

        sum     = (TOT_W+1)'(signed'(mem_rdata)) + (TOT_W+1)'(w_reg);
        ovf     = sum[TOT_W] != sum[TOT_W-1];
        sum_sat = ovf ? (sum[TOT_W] ? T_MIN : T_MAX) : TOT_W'(sum);

        read_ok   = (BIN_W'(rx_reg) < nx) && (BIN_W'(ry_reg) < ny);
        fill_addr = ADDR_W'(bx_reg) * ADDR_W'(MAX_BINS_Y) + ADDR_W'(by_reg);
        read_addr = ADDR_W'(rx_reg) * ADDR_W'(MAX_BINS_Y) + ADDR_W'(ry_reg);

        mem_we    = cmd.clr_step || cmd.wb_fill;
        mem_waddr = cmd.clr_step ? clr_reg : fill_addr;
        mem_wdata = cmd.clr_step ? '0 : unsigned'(sum_sat);
        mem_re    = cmd.rd_fill || cmd.rd_read;
        mem_raddr = cmd.rd_read ? read_addr : fill_addr;

        sts.n_zero   = n_sel == '0;
        sts.log_axis = log_sel;
        sts.found    = found;
        sts.last     = last;
        sts.clr_last = clr_reg == ADDR_W'(DEPTH - 1);
    end

    wh2d_ram #(
        .WIDTH (TOT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_init)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= clr_reg + ADDR_W'(1);
    end

    always_ff @(posedge clk)
    begin
        w_reg <= wa_reg * wb_reg;
        if (cmd.load)
        begin
            x_reg  <= sample_x;
            y_reg  <= sample_y;
            wa_reg <= weight_a;
            wb_reg <= weight_b;
            rx_reg <= read_bin_x;
            ry_reg <= read_bin_y;
        end
        if (cmd.ax_init)
        begin
            cur_reg  <= EDGE_W'(lo_sel);
            i_reg    <= '0;
            n_reg    <= n_sel;
            dneg_reg <= diff < 0;
            dq_reg   <= DIV_W'(dmag);
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? BIN_W'(rem_sh - {1'b0, n_reg}) : BIN_W'(rem_sh);
            dq_reg  <= {dq_reg[DIV_W-2:0], ge};
        end
        if (cmd.div_fix)
            step_reg <= dneg_reg ? -qext : qext;
        if (cmd.walk)
        begin
            if (found)
            begin
                if (cmd.axis)
                    by_reg <= i_reg;
                else
                    bx_reg <= i_reg;
            end
            else
            begin
                cur_reg <= nxt;
                i_reg   <= i_reg + BIN_W'(1);
            end
        end
        if (cmd.res_zero)
        begin
            hit_reg <= 1'b0;
            fbx_reg <= '0;
            fby_reg <= '0;
            tot_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.res_read)
        begin
            hit_reg <= read_ok;
            fbx_reg <= rx_reg;
            fby_reg <= ry_reg;
            tot_reg <= read_ok ? signed'(mem_rdata) : '0;
            sat_reg <= 1'b0;
        end
        else if (cmd.wb_fill)
        begin
            hit_reg <= 1'b1;
            fbx_reg <= IDX_W'(bx_reg);
            fby_reg <= IDX_W'(by_reg);
            tot_reg <= sum_sat;
            sat_reg <= ovf;
        end
    end

    assign hit         = hit_reg;
    assign found_bin_x = fbx_reg;
    assign found_bin_y = fby_reg;
    assign bin_total   = tot_reg;
    assign saturated   = sat_reg;

endmodule

// File: rtl/core/wh2d_ctrl.sv
// Controller FSM: sequences division, edge walk, store access and clearing.
// Depends on wh2d_pkg for command and status structs.
module wh2d_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      mode,
    input  logic            cfg_clear,
    input  wh2d_pkg::sts_t  sts,
    output wh2d_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);
    import wh2d_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AX_INIT,
        S_DIV,
        S_FIX,
        S_WALK,
        S_RD_FILL,
        S_WB,
        S_RD_READ,
        S_OUT_READ
    } state_t;

    state_t               state_reg, state_next;
    logic                 axis_reg, axis_next;
    logic [STEP_CW-1:0]   cnt_reg, cnt_next;
    logic                 clr_item_reg, clr_item_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        cnt_next      = cnt_reg;
        clr_item_next = clr_item_reg;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.axis      = axis_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (cfg_clear)
                begin
                    cmd.clr_init  = 1'b1;
                    clr_item_next = 1'b0;
                end
                else if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                    if (clr_item_reg)
                    begin
                        cmd.res_zero = 1'b1;
                        done_next    = 1'b1;
                    end
                end
            end
            S_IDLE:
            begin
                if (cfg_clear)
                begin
                    cmd.clr_init  = 1'b1;
                    clr_item_next = 1'b0;
                    state_next    = S_CLEAR;
                end
                else if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (mode)
                        MODE_FILL:
                        begin
                            axis_next  = 1'b0;
                            state_next = S_AX_INIT;
                        end
                        MODE_CLEAR:
                        begin
                            cmd.clr_init  = 1'b1;
                            clr_item_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        MODE_READ:
                            state_next = S_RD_READ;
                        default:
                        begin
                            cmd.res_zero = 1'b1;
                            done_next    = 1'b1;
                        end
                    endcase
                end
            end
            S_AX_INIT:
            begin
                cmd.ax_init = 1'b1;
                cnt_next    = '0;
                if (sts.n_zero)
                begin
                    cmd.res_zero = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (sts.log_axis)
                    state_next = S_WALK;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + STEP_CW'(1);
                if (cnt_reg == STEP_CW'(DIV_STEPS - 1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.found)
                begin
                    if (axis_reg)
                        state_next = S_RD_FILL;
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = S_AX_INIT;
                    end
                end
                else if (sts.last)
                begin
                    cmd.res_zero = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RD_FILL:
            begin
                cmd.rd_fill = 1'b1;
                state_next  = S_WB;
            end
            S_WB:
            begin
                cmd.wb_fill = 1'b1;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_RD_READ:
            begin
                cmd.rd_read = 1'b1;
                state_next  = S_OUT_READ;
            end
            S_OUT_READ:
            begin
                cmd.res_read = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            axis_reg     <= 1'b0;
            cnt_reg      <= '0;
            clr_item_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            cnt_reg      <= cnt_next;
            clr_item_reg <= clr_item_next;
            done_reg     <= done_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= STEP_CW'(DIV_STEPS - 1)))
        else $error("divider step count overran");

    a_fill_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cfg_clear && mode == MODE_FILL) |=> !done_reg)
        else $error("fill request produced a result in the next cycle");

    a_store_access_on_y: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_FILL || state_reg == S_WB) |-> axis_reg)
        else $error("store access before the y bin was found");

    a_clear_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !(cmd.rd_fill || cmd.wb_fill || cmd.rd_read))
        else $error("store access during the clearing pass");

endmodule

// File: bench/weighted_2d_histogram_binner_checker.sv
// Checker for the weighted 2D histogram binner: mirrors registers and the bin store,
// predicts each request's result and compares it with the block's. Needs wh2d_pkg.
`timescale 1ns / 1ps

module weighted_2d_histogram_binner_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wh2d_pkg::PADDR_W-1:0]       paddr,
    input  logic [wh2d_pkg::PDATA_W-1:0]       pwdata,
    input  logic                               pready,
    input  logic                               start,
    input  logic                               busy,
    input  logic [1:0]                         mode,
    input  logic signed [wh2d_pkg::VAL_W-1:0]  sample_x,
    input  logic signed [wh2d_pkg::VAL_W-1:0]  sample_y,
    input  logic signed [wh2d_pkg::W_W-1:0]    weight_a,
    input  logic signed [wh2d_pkg::W_W-1:0]    weight_b,
    input  logic [wh2d_pkg::IDX_W-1:0]         read_bin_x,
    input  logic [wh2d_pkg::IDX_W-1:0]         read_bin_y,
    input  logic                               done,
    input  logic                               hit,
    input  logic [wh2d_pkg::IDX_W-1:0]         found_bin_x,
    input  logic [wh2d_pkg::IDX_W-1:0]         found_bin_y,
    input  logic signed [wh2d_pkg::TOT_W-1:0]  bin_total,
    input  logic                               saturated,
    output int                                 fails,
    output int                                 pending
);
    import wh2d_pkg::*;

    localparam longint TOTAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint TOTAL_MIN = -TOTAL_MAX - 1;

    typedef struct {
        logic             hit;
        logic [IDX_W-1:0] bx;
        logic [IDX_W-1:0] by;
        logic [TOT_W-1:0] total;
        logic             sat;
    } bin_result_t;

    bin_result_t expected_bins[$];
    longint      totals[DEPTH];
    cfg_t        cfg;

    assign pending = expected_bins.size();

    // Bin holding v on one axis, or -1.
    function automatic int locate_bin(longint v, longint lo, longint hi, int n, int lim,
                                      bit lg);
        longint step;
        longint cur;
        longint nxt;
        if (n > lim)
            n = lim;
        if (n == 0)
            return -1;
        step = (hi - lo) / n;
        cur = lo;
        for (int i = 0; i < n; i++)
        begin
            if (lg)
            begin
                nxt = cur * 10;
                if (nxt > 64'sd2147483647)
                    nxt = 64'sd2147483647;
                if (nxt < -64'sd2147483648)
                    nxt = -64'sd2147483648;
            end
            else if (i + 1 == n)
                nxt = hi;
            else
                nxt = lo + (i + 1) * step;
            if (v >= cur && v < nxt)
                return i;
            cur = nxt;
        end
        return -1;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    task automatic apply_request();
        bin_result_t r;
        int          bx;
        int          by;
        int          k;
        int          nx;
        int          ny;
        longint      sum;
        r = '{0, 0, 0, 0, 0};
        if (mode == MODE_FILL)
        begin
            bx = locate_bin(longint'(sample_x), longint'(cfg.x_lo), longint'(cfg.x_hi),
                            int'(cfg.x_cnt), MAX_BINS_X, cfg.x_log);
            by = locate_bin(longint'(sample_y), longint'(cfg.y_lo), longint'(cfg.y_hi),
                            int'(cfg.y_cnt), MAX_BINS_Y, cfg.y_log);
            if (bx >= 0 && by >= 0)
            begin
                k = bx * MAX_BINS_Y + by;
                sum = totals[k] + longint'(weight_a) * longint'(weight_b);
                if (sum > TOTAL_MAX)
                begin
                    sum = TOTAL_MAX;
                    r.sat = 1;
                end
                if (sum < TOTAL_MIN)
                begin
                    sum = TOTAL_MIN;
                    r.sat = 1;
                end
                totals[k] = sum;
                r.hit = 1;
                r.bx = bx;
                r.by = by;
                r.total = sum[TOT_W-1:0];
            end
        end
        else if (mode == MODE_CLEAR)
            totals = '{default: 0};
        else if (mode == MODE_READ)
        begin
            nx = (cfg.x_cnt > MAX_BINS_X) ? MAX_BINS_X : int'(cfg.x_cnt);
            ny = (cfg.y_cnt > MAX_BINS_Y) ? MAX_BINS_Y : int'(cfg.y_cnt);
            r.bx = read_bin_x;
            r.by = read_bin_y;
            if (read_bin_x < nx && read_bin_y < ny)
            begin
                r.hit = 1;
                r.total = totals[read_bin_x * MAX_BINS_Y + read_bin_y][TOT_W-1:0];
            end
        end
        expected_bins.push_back(r);
    endtask

    task automatic apply_write();
        case (paddr[4:2])
            REG_X_LO:  cfg.x_lo = pwdata;
            REG_X_HI:  cfg.x_hi = pwdata;
            REG_Y_LO:  cfg.y_lo = pwdata;
            REG_Y_HI:  cfg.y_hi = pwdata;
            REG_X_CNT:
            begin
                cfg.x_cnt = pwdata[CNT_W-1:0];
                totals = '{default: 0};
            end
            REG_Y_CNT:
            begin
                cfg.y_cnt = pwdata[CNT_W-1:0];
                totals = '{default: 0};
            end
            REG_X_LOG: cfg.x_log = pwdata[0];
            REG_Y_LOG: cfg.y_log = pwdata[0];
            default: ;
        endcase
    endtask

    task automatic compare_result();
        bin_result_t w;
        if (expected_bins.size() == 0)
        begin
            $display("MISMATCH result with no request waiting at %0t", $realtime);
            fails++;
            return;
        end
        w = expected_bins.pop_front();
        if (hit !== w.hit)
            report("hit", hit, w.hit);
        if (found_bin_x !== w.bx)
            report("found_bin_x", found_bin_x, w.bx);
        if (found_bin_y !== w.by)
            report("found_bin_y", found_bin_y, w.by);
        if (bin_total !== w.total)
            report("bin_total", longint'(bin_total), longint'($signed(w.total)));
        if (saturated !== w.sat)
            report("saturated", saturated, w.sat);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            totals = '{default: 0};
            cfg = '{0, 65536, 0, 65536, 32, 32, 0, 0};
            expected_bins.delete();
            fails = 0;
        end
        else
        begin
            if (done)
                compare_result();
            if (psel && penable && pwrite && pready)
                apply_write();
            if (start && !busy)
                apply_request();
        end
    end

endmodule

// File: bench/weighted_2d_histogram_binner_tb.sv
// Testbench top for the weighted 2D histogram binner: clock, reset, register setups
// and request stimulus. Needs wh2d_pkg, the block and weighted_2d_histogram_binner_checker.
`timescale 1ns / 1ps

module weighted_2d_histogram_binner_tb;
    import wh2d_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] x_lo, x_hi, y_lo, y_hi, x_cnt, y_cnt, x_log, y_log;
    } setup_t;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start = 0;
    logic               busy;
    logic [1:0]         mode = '0;
    logic signed [VAL_W-1:0] sample_x = '0, sample_y = '0;
    logic signed [W_W-1:0]   weight_a = '0, weight_b = '0;
    logic [IDX_W-1:0]   read_bin_x = '0, read_bin_y = '0;
    logic               done, hit, saturated;
    logic [IDX_W-1:0]   found_bin_x, found_bin_y;
    logic signed [TOT_W-1:0] bin_total;
    int                 fails, pending;

    setup_t setups[5];
    setup_t cur;

    weighted_2d_histogram_binner dut (.*);
    weighted_2d_histogram_binner_checker checker_i (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Hold off until the block is idle and nothing is outstanding.
    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic load_setup(setup_t s);
        drain();
        reg_write(REG_X_LO, s.x_lo);
        reg_write(REG_X_HI, s.x_hi);
        reg_write(REG_Y_LO, s.y_lo);
        reg_write(REG_Y_HI, s.y_hi);
        reg_write(REG_X_CNT, s.x_cnt);
        reg_write(REG_Y_CNT, s.y_cnt);
        reg_write(REG_X_LOG, s.x_log);
        reg_write(REG_Y_LOG, s.y_log);
        cur = s;
    endtask

    task automatic issue(logic [1:0] m, logic [31:0] x, logic [31:0] y, logic [15:0] a,
                         logic [15:0] b, logic [4:0] rx, logic [4:0] ry);
        start <= 1;
        mode <= m;
        sample_x <= x;
        sample_y <= y;
        weight_a <= a;
        weight_b <= b;
        read_bin_x <= rx;
        read_bin_y <= ry;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle(int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 0;
            @(posedge clk);
        end
    endtask

    // Mostly values inside the configured range so fills land in bins.
    function automatic logic [31:0] pick_value(logic [31:0] lo_r, logic [31:0] hi_r,
                                               logic lg);
        longint lo;
        longint hi;
        longint v;
        lo = longint'($signed(lo_r));
        hi = longint'($signed(hi_r));
        if ($urandom_range(9) < 2)
            return $urandom;
        if (lg)
            v = lo * (64'sd1 << $urandom_range(0, 14)) + $urandom_range(0, 255);
        else if (hi > lo)
            v = lo + longint'($urandom) % (hi - lo);
        else
            return $urandom;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic random_request(int pct);
        int r;
        r = $urandom_range(99);
        idle(pct);
        if (r < 72)
            issue(MODE_FILL, pick_value(cur.x_lo, cur.x_hi, cur.x_log[0]),
                  pick_value(cur.y_lo, cur.y_hi, cur.y_log[0]), $urandom, $urandom, 0, 0);
        else if (r < 90)
            issue(MODE_READ, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 31), $urandom_range(0, 31));
        else if (r < 93)
            issue(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            issue(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int profile[3];
        profile = '{0, 88, 29};
        setups[0] = '{32'h0, 32'h10000, 32'hFFFF0000, 32'h10000, 32, 8, 0, 0};
        setups[1] = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFC18, 32'd1000, 1, 63, 0, 0};
        setups[2] = '{32'd1, 32'h0, 32'h10000, 32'h0, 32, 5, 1, 1};
        setups[3] = '{32'hFFFFFED4, 32'd300, 32'hFFFF0000, 32'h0, 7, 4, 0, 1};
        setups[4] = '{32'd5000, 32'hFFFFEC78, 32'h0, 32'h7FFFFFFF, 0, 31, 0, 0};
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // Directed: edges, weight extremes, every mode, reads in and out of range.
        load_setup(setups[0]);
        issue(MODE_FILL, 32'h0, 32'hFFFF0000, 16'h8000, 16'h8000, 0, 0);
        issue(MODE_FILL, 32'h0, 32'hFFFF0000, 16'h7FFF, 16'h8000, 0, 0);
        issue(MODE_FILL, 32'hFFFF, 32'hFFFF, 16'h7FFF, 16'h7FFF, 0, 0);
        issue(MODE_FILL, 32'h10000, 32'h0, 16'h0100, 16'h0100, 0, 0);
        issue(MODE_FILL, 32'hFFFFFFFF, 32'h0, 16'h0100, 16'h0100, 0, 0);
        issue(MODE_FILL, 32'h800, 32'h10000, 16'h0100, 16'h0100, 0, 0);
        issue(MODE_FILL, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 16'h0000, 0, 0);
        issue(MODE_READ, 0, 0, 0, 0, 0, 0);
        issue(MODE_READ, 0, 0, 0, 0, 31, 7);
        issue(MODE_READ, 0, 0, 0, 0, 31, 8);
        issue(MODE_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 31, 31);
        issue(MODE_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 31, 31);
        issue(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
        issue(MODE_READ, 0, 0, 0, 0, 0, 0);
        load_setup(setups[4]);
        issue(MODE_FILL, 32'd0, 32'd100, 16'h0100, 16'h0100, 0, 0);
        issue(MODE_READ, 0, 0, 0, 0, 0, 0);
        load_setup(setups[2]);
        issue(MODE_FILL, 32'd1, 32'h10000, 16'h0200, 16'h0300, 0, 0);
        issue(MODE_FILL, 32'h7FFFFFFE, 32'h7FFFFFFE, 16'h0200, 16'h0300, 0, 0);
        issue(MODE_FILL, 32'd0, 32'd0, 16'h0200, 16'h0300, 0, 0);
        issue(MODE_READ, 0, 0, 0, 0, 0, 0);

        for (int p = 0; p < 8; p++)
        begin
            load_setup(setups[p % 5]);
            for (int i = 0; i < 112; i++)
            begin
                random_request(profile[p % 3]);
                if (p == 3 && i == 50)
                    drain();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/wh2d_pkg.sv
rtl/core/wh2d_ram.sv
rtl/core/wh2d_regs.sv
rtl/core/wh2d_dp.sv
rtl/core/wh2d_ctrl.sv
rtl/core/weighted_2d_histogram_binner.sv
bench/weighted_2d_histogram_binner_checker.sv
bench/weighted_2d_histogram_binner_tb.sv
